/* hw/rtl/spectrum_amplitude_colormap_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the amplitude colormap RTL. They
// expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_AMPLITUDE_COLORMAP_ASSERT_SVH
`define SPECTRUM_AMPLITUDE_COLORMAP_ASSERT_SVH
`ifndef SYNTHESIS
`define SAC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SAC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define SAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/sac_pkg.sv */
// ----------------------------------------------------------------------------
// Amplitude colormap package
// Default widths and the color channel constants shared by the colormap RTL.
// ----------------------------------------------------------------------------
package sac_pkg;

    localparam int AMP_BITS_DEF  = 24;
    localparam int FRAC_BITS_DEF = 16;

    localparam int PIX_W  = 32;
    localparam int COEF_W = 13;

    localparam logic [COEF_W-1:0] RED_COEF   = 13'd2295;
    localparam logic [COEF_W-1:0] GREEN_COEF = 13'd3825;
    localparam logic [COEF_W-1:0] BLUE_COEF  = 13'd4335;

    localparam logic [7:0] CHAN_MAX   = 8'hFF;
    localparam logic [7:0] ALPHA_FULL = 8'hFF;

endpackage

/* hw/rtl/spectrum_amplitude_colormap.sv */
// ----------------------------------------------------------------------------
// Spectrum amplitude colormap
// Maps an unsigned spectrum amplitude, normalized against a programmable
// peak, to a packed RGBA8888 pixel through three Bernstein polynomials.
//
//   Channel   Direction  Ports                        Payload
//   s_        in         s_tvalid s_tready s_tdata    amplitude
//   m_        out        m_tvalid m_tready m_tdata    pixel
//   cfg_      in         cfg_we cfg_wdata             peak
//
// One transfer in and one out per cycle while m_tready stays high. The data
// path is the scaling multiplier, the one-bit-per-stage divider (FRAC_BITS + 1
// stages) and the four polynomial stages.
// Reset clears all valid bits and sets the peak to all ones.
// Each stage holds while the next one is full and stalled; empty stages keep
// accepting, so no transfer is lost or repeated.
// ----------------------------------------------------------------------------
`include "spectrum_amplitude_colormap_assert.svh"

module spectrum_amplitude_colormap #(
    parameter int AMP_BITS  = sac_pkg::AMP_BITS_DEF,
    parameter int FRAC_BITS = sac_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [AMP_BITS-1:0]                cfg_wdata,   // peak
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((AMP_BITS+7)/8)*8-1:0]      s_tdata,     // amplitude
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sac_pkg::PIX_W-1:0]          m_tdata      // pixel
);

    logic [AMP_BITS-1:0] peak_reg;
    logic                t_valid;
    logic                t_ready;
    logic [FRAC_BITS:0]  t_val;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg <= '1;
        end else if (cfg_we) begin
            peak_reg <= cfg_wdata;
        end
    end

    sac_div #(
        .AMP_BITS  (AMP_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .peak      (peak_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .amplitude (s_tdata[AMP_BITS-1:0]),
        .out_valid (t_valid),
        .out_ready (t_ready),
        .t_out     (t_val)
    );

    sac_poly #(
        .FRAC_BITS (FRAC_BITS)
    ) u_poly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (t_valid),
        .in_ready  (t_ready),
        .t_in      (t_val),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .pixel     (m_tdata)
    );

    `SAC_ASSERT_IMPLY(a_ready_when_drained, aclk, aresetn, m_tready, s_tready)
    `SAC_ASSERT_NEXT(a_cfg_written, aclk, aresetn, cfg_we, peak_reg == $past(cfg_wdata))
    `SAC_ASSERT_NEXT(a_peak_held, aclk, aresetn, !cfg_we, $stable(peak_reg))

endmodule

/* hw/rtl/sac_div.sv */
// ----------------------------------------------------------------------------
// Amplitude normalizer
// Scales the amplitude by 0.8 and divides it by the peak in a pipelined
// restoring divider, one quotient bit per stage, clamping the result to one.
// ----------------------------------------------------------------------------
`include "spectrum_amplitude_colormap_assert.svh"

module sac_div #(
    parameter int AMP_BITS  = sac_pkg::AMP_BITS_DEF,
    parameter int FRAC_BITS = sac_pkg::FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [AMP_BITS-1:0]  peak,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [AMP_BITS-1:0]  amplitude,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [FRAC_BITS:0]   t_out
);

    localparam int N_W    = AMP_BITS + FRAC_BITS;
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int STAGES = Q_W + 1;
    localparam logic [FRAC_BITS-1:0] SCALE =
        FRAC_BITS'(((1 << (FRAC_BITS + 2)) + 2) / 5);
    localparam logic [Q_W-1:0] ONE = Q_W'(1) << FRAC_BITS;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES:0]   rdy;
    logic [N_W-1:0]    rem_reg [STAGES];
    logic [Q_W-1:0]    quo_reg [1:Q_W];
    logic              ovf_reg [1:Q_W];
    logic [N_W-1:0]    prod;

    assign rdy[STAGES] = out_ready;
    assign in_ready    = rdy[0];
    assign prod        = N_W'(amplitude) * N_W'(SCALE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (rdy[0]) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0] && in_valid) begin
            rem_reg[0] <= prod;
        end
    end

    assign rdy[0] = !valid_reg[0] || rdy[1];

    for (genvar j = 1; j < STAGES; j++) begin : g_stage
        localparam int SH = Q_W - j;
        logic [N_W-1:0] dvs;
        logic           ge;
        logic           ovf_in;
        logic [Q_W-1:0] quo_in;

        assign dvs    = N_W'(peak) << SH;
        assign ge     = rem_reg[j-1] >= dvs;
        assign rdy[j] = !valid_reg[j] || rdy[j+1];

        if (j == 1) begin : g_first
            assign ovf_in = {1'b0, rem_reg[0]} >= ((N_W + 1)'(peak) << Q_W);
            assign quo_in = '0;
        end else begin : g_rest
            assign ovf_in = ovf_reg[j-1];
            assign quo_in = quo_reg[j-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (rdy[j]) begin
                valid_reg[j] <= valid_reg[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[j] && valid_reg[j-1]) begin
                rem_reg[j] <= ge ? (rem_reg[j-1] - dvs) : rem_reg[j-1];
                quo_reg[j] <= {quo_in[Q_W-2:0], ge};
                ovf_reg[j] <= ovf_in;
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign t_out = (ovf_reg[Q_W] || (quo_reg[Q_W] > ONE)) ? ONE : quo_reg[Q_W];

    `SAC_ASSERT_IMPLY(a_rem_below_divisor, aclk, aresetn,
        valid_reg[Q_W] && !ovf_reg[Q_W], rem_reg[Q_W] < N_W'(peak))
    `SAC_ASSERT_IMPLY(a_zero_peak_overflows, aclk, aresetn,
        valid_reg[1] && (peak == '0), ovf_reg[1])
    `SAC_ASSERT_IMPLY(a_t_clamped, aclk, aresetn, out_valid, t_out <= ONE)

endmodule

/* hw/rtl/sac_poly.sv */
// ----------------------------------------------------------------------------
// Color polynomial pipeline
// Evaluates the three Bernstein-style channel polynomials of t in four
// register stages and packs the RGBA8888 pixel word.
// ----------------------------------------------------------------------------
`include "spectrum_amplitude_colormap_assert.svh"

module sac_poly #(
    parameter int FRAC_BITS = sac_pkg::FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [FRAC_BITS:0]        t_in,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [sac_pkg::PIX_W-1:0] pixel
);

    localparam int Q_W = FRAC_BITS + 1;
    localparam int C_W = sac_pkg::COEF_W;
    localparam int R_W = Q_W + C_W;
    localparam logic [Q_W-1:0] ONE = Q_W'(1) << FRAC_BITS;

    function automatic logic [Q_W-1:0] qmul(input logic [Q_W-1:0] a,
                                            input logic [Q_W-1:0] b);
        logic [2*Q_W-1:0] p;
        p = (2*Q_W)'(a) * (2*Q_W)'(b);
        return p[FRAC_BITS +: Q_W];
    endfunction

    function automatic logic [7:0] sat8(input logic [C_W:0] v);
        return (v > (C_W + 1)'(sac_pkg::CHAN_MAX)) ? sac_pkg::CHAN_MAX : v[7:0];
    endfunction

    logic [3:0] valid_reg;
    logic [4:0] rdy;

    logic [Q_W-1:0] s1_t, s1_u, s1_tt, s1_uu;
    logic [Q_W-1:0] s2_t, s2_u, s2_ttt, s2_uut, s2_uuu;
    logic [Q_W-1:0] s3_r, s3_g, s3_b;
    logic [sac_pkg::PIX_W-1:0] pixel_reg;

    logic [Q_W-1:0] u_in;
    logic [R_W-1:0] red_p, green_p, blue_p;

    assign rdy[4]   = out_ready;
    assign in_ready = rdy[0];
    for (genvar k = 0; k < 4; k++) begin : g_rdy
        assign rdy[k] = !valid_reg[k] || rdy[k+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (rdy[0]) begin
                valid_reg[0] <= in_valid;
            end
            if (rdy[1]) begin
                valid_reg[1] <= valid_reg[0];
            end
            if (rdy[2]) begin
                valid_reg[2] <= valid_reg[1];
            end
            if (rdy[3]) begin
                valid_reg[3] <= valid_reg[2];
            end
        end
    end

    assign u_in    = ONE - t_in;
    assign red_p   = R_W'(s3_r) * R_W'(sac_pkg::RED_COEF);
    assign green_p = R_W'(s3_g) * R_W'(sac_pkg::GREEN_COEF);
    assign blue_p  = R_W'(s3_b) * R_W'(sac_pkg::BLUE_COEF);

    always_ff @(posedge aclk) begin
        if (rdy[0] && in_valid) begin
            s1_t  <= t_in;
            s1_u  <= u_in;
            s1_tt <= qmul(t_in, t_in);
            s1_uu <= qmul(u_in, u_in);
        end
        if (rdy[1] && valid_reg[0]) begin
            s2_t   <= s1_t;
            s2_u   <= s1_u;
            s2_ttt <= qmul(s1_tt, s1_t);
            s2_uut <= qmul(s1_uu, s1_t);
            s2_uuu <= qmul(s1_uu, s1_u);
        end
        if (rdy[2] && valid_reg[1]) begin
            s3_r <= qmul(s2_ttt, s2_u);
            s3_g <= qmul(s2_uut, s2_t);
            s3_b <= qmul(s2_uuu, s2_t);
        end
        if (rdy[3] && valid_reg[2]) begin
            pixel_reg <= {sat8(red_p[FRAC_BITS +: C_W+1]),
                          sat8(green_p[FRAC_BITS +: C_W+1]),
                          sat8({1'b0, blue_p[FRAC_BITS+1 +: C_W]}),
                          sac_pkg::ALPHA_FULL};
        end
    end

    assign out_valid = valid_reg[3];
    assign pixel     = pixel_reg;

    `SAC_ASSERT_IMPLY(a_t_plus_u_is_one, aclk, aresetn, valid_reg[0], (s1_t + s1_u) == ONE)
    `SAC_ASSERT_IMPLY(a_alpha_full, aclk, aresetn, out_valid, pixel[7:0] == sac_pkg::ALPHA_FULL)
    `SAC_ASSERT_NEXT(a_hold_on_stall, aclk, aresetn,
        out_valid && !out_ready, out_valid && $stable(pixel))

endmodule

/* bench/tb_spectrum_amplitude_colormap.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Amplitude colormap testbench
// Streams spectrum amplitudes into the colormap under several peak
// settings and checks every output pixel against a fixed-point model of the
// Bernstein color curves. Both stream sides idle at random, with one phase
// run at full rate, and the sender drains the pipeline before every
// peak change.
// ----------------------------------------------------------------------------
module tb_spectrum_amplitude_colormap;

    localparam int          FRAC_W      = sac_pkg::FRAC_BITS_DEF;
    localparam int          LATENCY     = FRAC_W + 6;
    localparam int          STALL_LIMIT = 5000;
    localparam logic [63:0] Q_ONE       = 64'd1 << FRAC_W;
    localparam logic [63:0] GAIN_08     = ((64'd1 << (FRAC_W + 2)) + 64'd2) / 64'd5;
    localparam logic [23:0] AMP_FULL    = 24'hFFFFFF;

    class pixel_scoreboard;
        logic [23:0] peak;
        logic [31:0] pending_pixels[$];
        int          errors;
        int          noted;
        int          checked;

        function new();
            peak      = AMP_FULL;
            errors    = 0;
            noted     = 0;
            checked   = 0;
        endfunction

        function void set_max(logic [23:0] v);
            peak = v;
        endfunction

        function logic [63:0] frac_mul(logic [63:0] a, logic [63:0] b);
            return (a * b) >> FRAC_W;
        endfunction

        function logic [7:0] clip8(logic [63:0] v);
            return (v > 64'd255) ? sac_pkg::CHAN_MAX : v[7:0];
        endfunction

        function logic [31:0] amplitude_to_rgba(logic [23:0] amp);
            logic [63:0] t;
            logic [63:0] u;
            logic [63:0] r;
            logic [63:0] g;
            logic [63:0] b;
            if (peak == 24'd0) begin
                t = Q_ONE;
            end else begin
                t = (64'(amp) * GAIN_08) / 64'(peak);
                if (t > Q_ONE) begin
                    t = Q_ONE;
                end
            end
            u = Q_ONE - t;
            r = (64'(sac_pkg::RED_COEF) * frac_mul(frac_mul(frac_mul(t, t), t), u)) >> FRAC_W;
            g = (64'(sac_pkg::GREEN_COEF) * frac_mul(frac_mul(frac_mul(u, u), t), t)) >> FRAC_W;
            b = (64'(sac_pkg::BLUE_COEF) * frac_mul(frac_mul(frac_mul(u, u), u), t))
                >> (FRAC_W + 1);
            return {clip8(r), clip8(g), clip8(b), sac_pkg::ALPHA_FULL};
        endfunction

        function void note_amplitude(logic [23:0] amp);
            pending_pixels.push_back(amplitude_to_rgba(amp));
            noted++;
        endfunction

        function void check_pixel(logic [31:0] px);
            logic [31:0] want;
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel transfer, expected none, got %08h", $time, px);
                errors++;
            end else begin
                want = pending_pixels.pop_front();
                checked++;
                if (px !== want) begin
                    $display("%0t: pixel mismatch, expected %08h, got %08h", $time, want, px);
                    errors++;
                end
            end
        endfunction

        function void check_leftovers();
            if (pending_pixels.size() != 0) begin
                $display("%0t: %0d pixels missing, expected %08h next, got nothing",
                         $time, pending_pixels.size(), pending_pixels[0]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [23:0] cfg_wdata = 24'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = 24'd0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;

    pixel_scoreboard sb;
    bit              steady       = 1'b0;
    int              stall_cycles = 0;
    int              settings_run = 0;

    spectrum_amplitude_colormap DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 16);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            sb.check_pixel(m_tdata);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("[spectrum_amplitude_colormap] ERROR");
            $finish;
        end
    end

    task automatic send_amplitude(input logic [23:0] amp);
        while (!steady && $urandom_range(0, 99) < 16) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= amp;
        do begin
            @(posedge aclk);
        end while (s_tready !== 1'b1);
        sb.note_amplitude(amp);
        @(negedge aclk);
    endtask

    task automatic drain_pixels();
        s_tvalid <= 1'b0;
        do begin
            @(negedge aclk);
        end while (sb.pending_pixels.size() != 0);
    endtask

    task automatic write_max(input logic [23:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        sb.set_max(v);
        settings_run++;
    endtask

    // Most amplitudes land in the range where t runs from zero to its clamp,
    // some sit right at the clamp point, and the rest span the whole field.
    function automatic logic [23:0] pick_amplitude(logic [23:0] mx);
        int          sel;
        int          knee;
        logic [25:0] span;
        sel  = $urandom_range(0, 99);
        span = 26'(mx) + 26'(mx >> 2);
        if (span > 26'(AMP_FULL)) begin
            span = 26'(AMP_FULL);
        end
        if (sel < 70) begin
            return 24'($urandom_range(0, 32'(span)));
        end else if (sel < 85) begin
            knee = int'(span) + int'($urandom_range(0, 8)) - 4;
            if (knee < 0) begin
                knee = 0;
            end
            if (knee > int'(AMP_FULL)) begin
                knee = int'(AMP_FULL);
            end
            return 24'(knee);
        end
        return 24'($urandom);
    endfunction

    initial begin
        logic [23:0] top_max_amps[7];
        logic [23:0] mid_max_amps[8];
        logic [23:0] zero_max_amps[3];
        logic [23:0] phase_max[7];
        int          phase_len[7];

        sb = new();
        top_max_amps  = '{24'd0, 24'd1, AMP_FULL, 24'h800000, 24'hAAAAAA, 24'h555555,
                          24'h400000};
        mid_max_amps  = '{24'd0, 24'd1000, 24'd1249, 24'd1250, 24'd1251, 24'd500, 24'd625,
                          AMP_FULL};
        zero_max_amps = '{24'd0, 24'd1, AMP_FULL};
        phase_max     = '{AMP_FULL, 24'd0, 24'd1, 24'd1000, 24'($urandom_range(2, 32'hFFFFFE)),
                          AMP_FULL, 24'd37};
        phase_len     = '{185, 40, 185, 185, 185, 185, 185};

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (top_max_amps[i]) begin
            send_amplitude(top_max_amps[i]);
        end
        drain_pixels();
        write_max(24'd1000);
        foreach (mid_max_amps[i]) begin
            send_amplitude(mid_max_amps[i]);
        end
        drain_pixels();
        write_max(24'd0);
        foreach (zero_max_amps[i]) begin
            send_amplitude(zero_max_amps[i]);
        end

        foreach (phase_max[p]) begin
            drain_pixels();
            write_max(phase_max[p]);
            steady = (p == 4);
            repeat (phase_len[p]) begin
                send_amplitude(pick_amplitude(phase_max[p]));
            end
        end
        steady = 1'b0;

        drain_pixels();
        repeat (LATENCY + 4) @(negedge aclk);
        sb.check_leftovers();

        $display("Sent %0d amplitudes across %0d peak settings, including zero and full scale.",
                 sb.noted, settings_run);
        $display("Checked %0d pixels with %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("[spectrum_amplitude_colormap] OK");
        end else begin
            $display("[spectrum_amplitude_colormap] ERROR");
        end
        $finish;
    end

endmodule

/* spectrum_amplitude_colormap.f */
+incdir+hw/rtl
hw/rtl/sac_pkg.sv
hw/rtl/sac_div.sv
hw/rtl/sac_poly.sv
hw/rtl/spectrum_amplitude_colormap.sv
bench/tb_spectrum_amplitude_colormap.sv
